>>> src/assert_macros.svh
// Assertion macros for the checker module of the oscillator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cnco_pkg.sv
// Shared constants, register codes and sine table arithmetic of the oscillator.
package cnco_pkg;

    // Default values of the top level parameters.
    localparam int PHASE_BITS_DEF  = 32;
    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int MAX_SAMPLES_DEF = 65536;

    // Port widths.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;

    // Register widths and reset values.
    localparam int CNT_REG_W = 17;
    localparam logic [CNT_REG_W-1:0] SAMPLE_COUNT_RST = 17'd1024;

    // Register indexes, taken from the word address.
    typedef enum logic [1:0] {
        REG_PHASE_STEP   = 2'd0,
        REG_START_PHASE  = 2'd1,
        REG_SAMPLE_COUNT = 2'd2
    } reg_idx_t;

    // Quadrant of the phase, from its two top bits.
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Quarter turn in unsigned Q2.62.
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // Low 64 bits of (a * b) >> sh; used only while the table is built.
    function automatic logic [63:0] mulshr(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return p[63:0];
    endfunction

    // Entry k of the quarter-wave table: round(A * sin(pi/2 * k / 2^tb)),
    // A = 2^(sb-1) - 1, by a Taylor series in Q2.62 carried to the x^29 term.
    function automatic logic [31:0] rom_entry(input int k, input int tb, input int sb);
        logic [63:0] kk;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] amp;
        logic [63:0] r;
        kk   = 64'(k);
        x    = (HALF_PI_Q62 >> tb) * kk
             + (((HALF_PI_Q62 & ((64'd1 << tb) - 64'd1)) * kk) >> tb);
        x2   = mulshr(x, x, 62);
        term = x;
        pos  = x;
        neg  = 64'd0;
        term = mulshr(term, x2, 62) / 64'd6;   neg = neg + term;
        term = mulshr(term, x2, 62) / 64'd20;  pos = pos + term;
        term = mulshr(term, x2, 62) / 64'd42;  neg = neg + term;
        term = mulshr(term, x2, 62) / 64'd72;  pos = pos + term;
        term = mulshr(term, x2, 62) / 64'd110; neg = neg + term;
        term = mulshr(term, x2, 62) / 64'd156; pos = pos + term;
        term = mulshr(term, x2, 62) / 64'd210; neg = neg + term;
        term = mulshr(term, x2, 62) / 64'd272; pos = pos + term;
        term = mulshr(term, x2, 62) / 64'd342; neg = neg + term;
        term = mulshr(term, x2, 62) / 64'd420; pos = pos + term;
        term = mulshr(term, x2, 62) / 64'd506; neg = neg + term;
        term = mulshr(term, x2, 62) / 64'd600; pos = pos + term;
        term = mulshr(term, x2, 62) / 64'd702; neg = neg + term;
        term = mulshr(term, x2, 62) / 64'd812; pos = pos + term;
        s    = pos - neg;
        amp  = (64'd1 << (sb - 1)) - 64'd1;
        r    = (mulshr(s, amp, 61) + 64'd1) >> 1;
        return r[31:0];
    endfunction

endpackage

>>> src/complex_nco_generator.sv
// Top level of the quadrature oscillator: phase accumulator, sine table and output stage.
//
// Usage. Each transfer on the s_ channel is one tick and gives exactly one complex
// sample on the m_ channel, in order. Bit 0 of s_tdata (restart) returns the phase to
// the start phase and the frame to its first sample before that tick's sample is made.
// m_tdata carries cosine and sine in Q1.15, m_tlast marks the final sample of a frame,
// and m_tuser flags a phase step of half a turn or more, in which case both samples
// are zero. The APB port writes phase_step (0x0), start_phase (0x4) and
// sample_count (0x8); it must be written only while no tick is in flight, which the
// block does not enforce. A sample passes the table stage, then the output register.
// Throughput is one tick per cycle unless the receiver stalls: the phase accumulator
// updates in the cycle of the transfer, and the table reads are registered on two ports.
// When the receiver stalls, the output register holds its sample and the table stage
// behind it still takes one more tick before s_tready falls.
// Reset (aresetn low, synchronous) clears the registers to their defaults, the phase to
// zero, the frame to its first sample and empties the pipeline. No clearing pass runs.
module complex_nco_generator #(
    parameter int PHASE_BITS  = cnco_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS  = cnco_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = cnco_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_SAMPLES = cnco_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Tick stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cnco_pkg::S_TDATA_W-1:0]   s_tdata,   // [0] restart, [7:1] zero
    // Sample stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cnco_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] cos_out, [31:16] sin_out
    output logic                             m_tlast,   // frame_last
    output logic                             m_tuser,   // [0] config_error
    // Register port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cnco_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [cnco_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [cnco_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import cnco_pkg::*;

    localparam int ROM_N   = 1 << TABLE_BITS;
    localparam int ADDR_W  = TABLE_BITS + 1;
    localparam int MAG_W   = SAMPLE_BITS - 1;
    localparam int IDX_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int CMP_W   = (CNT_REG_W > CNT_W) ? CNT_REG_W : CNT_W;
    localparam int SH_DN   = (SAMPLE_BITS > 16) ? SAMPLE_BITS - 16 : 1;
    localparam int SH_UP   = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam int RND_ADD = 1 << (SH_DN - 1);
    localparam int MAG_MAX = 32767;
    localparam int SCL_W   = MAG_W + 16;

    typedef logic [MAG_W-1:0] rom_t [ROM_N+1];

    // Quarter-wave sine table, built at elaboration.
    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= ROM_N; k++) begin
            r[k] = MAG_W'(rom_entry(k, TABLE_BITS, SAMPLE_BITS));
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // Bring a 32-bit register value to the accumulator's scale.
    function automatic logic [PHASE_BITS-1:0] align_phase(input logic [31:0] v);
        logic [PHASE_BITS+31:0] w;
        w = {v, PHASE_BITS'(0)};
        return w[PHASE_BITS+31:32];
    endfunction

    // Bring a table magnitude to 15 fraction bits, rounding half up and saturating.
    function automatic logic [14:0] scale_mag(input logic [MAG_W-1:0] m);
        logic [SCL_W-1:0] t;
        t = SCL_W'(m);
        if (SAMPLE_BITS > 16) begin
            t = (t + SCL_W'(RND_ADD)) >> SH_DN;
        end else if (SAMPLE_BITS < 16) begin
            t = t << SH_UP;
        end
        if (t > SCL_W'(MAG_MAX)) begin
            t = SCL_W'(MAG_MAX);
        end
        return t[14:0];
    endfunction

    // Configuration registers.
    logic [31:0]          phase_step_reg;
    logic [31:0]          start_phase_reg;
    logic [CNT_REG_W-1:0] sample_count_reg;
    logic                 cfg_wr;
    reg_idx_t             cfg_idx;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg   <= '0;
            start_phase_reg  <= '0;
            sample_count_reg <= SAMPLE_COUNT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_PHASE_STEP:   phase_step_reg   <= pwdata;
                REG_START_PHASE:  start_phase_reg  <= pwdata;
                REG_SAMPLE_COUNT: sample_count_reg <= pwdata[CNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_PHASE_STEP:   prdata = phase_step_reg;
            REG_START_PHASE:  prdata = start_phase_reg;
            REG_SAMPLE_COUNT: prdata = CFG_DATA_W'(sample_count_reg);
            default:          prdata = '0;
        endcase
    end

    // Pipeline handshake: the table stage moves on when the output register is free.
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic s_acc, adv1;

    assign adv1     = v1_reg && (!v2_reg || m_tready);
    assign s_tready = !v1_reg || adv1;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        v1_next = v1_reg;
        if (s_acc) begin
            v1_next = 1'b1;
        end else if (adv1) begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (adv1) begin
            v2_next = 1'b1;
        end else if (m_tready) begin
            v2_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Phase accumulator and sample index, updated on every tick transfer.
    logic [PHASE_BITS-1:0] phase_acc_reg, phase_acc_next;
    logic [IDX_W-1:0]      sample_index_reg, sample_index_next;
    logic [PHASE_BITS-1:0] start_al, step_al, cur_phase;
    logic [IDX_W-1:0]      cur_idx;
    logic [CMP_W-1:0]      cnt_ext, cnt_eff, idx_inc;
    logic                  restart, cur_last;

    assign restart   = s_tdata[0];
    assign start_al  = align_phase(start_phase_reg);
    assign step_al   = align_phase(phase_step_reg);
    assign cur_phase = restart ? start_al : phase_acc_reg;
    assign cur_idx   = restart ? '0 : sample_index_reg;
    assign cnt_ext   = CMP_W'(sample_count_reg);

    // A count of zero stands for one; a count beyond the frame limit is clipped.
    always_comb begin
        if (cnt_ext == '0) begin
            cnt_eff = CMP_W'(1);
        end else if (cnt_ext > CMP_W'(MAX_SAMPLES)) begin
            cnt_eff = CMP_W'(MAX_SAMPLES);
        end else begin
            cnt_eff = cnt_ext;
        end
    end

    assign idx_inc  = CMP_W'(cur_idx) + CMP_W'(1);
    assign cur_last = idx_inc >= cnt_eff;

    always_comb begin
        if (cur_last) begin
            phase_acc_next    = start_al;
            sample_index_next = '0;
        end else begin
            phase_acc_next    = cur_phase + step_al;
            sample_index_next = cur_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg    <= '0;
            sample_index_reg <= '0;
        end else if (s_acc) begin
            phase_acc_reg    <= phase_acc_next;
            sample_index_reg <= sample_index_next;
        end
    end

    // Table addresses: offset within the quadrant and its mirror.
    logic [TABLE_BITS+1:0] phase_top;
    logic [ADDR_W-1:0]     addr_a, addr_b;

    assign phase_top = cur_phase[PHASE_BITS-1 -: TABLE_BITS+2];
    assign addr_a    = {1'b0, phase_top[TABLE_BITS-1:0]};
    assign addr_b    = ADDR_W'(ROM_N) - addr_a;

    // Table stage: two registered reads and the tick's flags.
    logic [MAG_W-1:0] rom_a_reg, rom_b_reg;
    quad_t            quad1_reg;
    logic             last1_reg, err1_reg;

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            rom_a_reg <= SINE_ROM[addr_a];
            rom_b_reg <= SINE_ROM[addr_b];
            quad1_reg <= quad_t'(phase_top[TABLE_BITS+1:TABLE_BITS]);
            last1_reg <= cur_last;
            err1_reg  <= phase_step_reg[31];
        end
    end

    // Quadrant mapping and sign.
    logic [14:0] mag_a, mag_b;
    logic [15:0] pos_a, pos_b, neg_a, neg_b;
    logic [15:0] cos_val, sin_val;

    assign mag_a = scale_mag(rom_a_reg);
    assign mag_b = scale_mag(rom_b_reg);
    assign pos_a = {1'b0, mag_a};
    assign pos_b = {1'b0, mag_b};
    assign neg_a = 16'd0 - pos_a;
    assign neg_b = 16'd0 - pos_b;

    always_comb begin
        case (quad1_reg)
            QUAD_0: begin
                cos_val = pos_b;
                sin_val = pos_a;
            end
            QUAD_1: begin
                cos_val = neg_a;
                sin_val = pos_b;
            end
            QUAD_2: begin
                cos_val = neg_b;
                sin_val = neg_a;
            end
            default: begin
                cos_val = pos_a;
                sin_val = neg_b;
            end
        endcase
        if (err1_reg) begin
            cos_val = '0;
            sin_val = '0;
        end
    end

    // Output register.
    logic [15:0] cos_reg, sin_reg;
    logic        last2_reg, err2_reg;

    always_ff @(posedge aclk) begin
        if (adv1) begin
            cos_reg   <= cos_val;
            sin_reg   <= sin_val;
            last2_reg <= last1_reg;
            err2_reg  <= err1_reg;
        end
    end

    assign m_tvalid = v2_reg;
    assign m_tdata  = {sin_reg, cos_reg};
    assign m_tlast  = last2_reg;
    assign m_tuser  = err2_reg;

endmodule

>>> src/cnco_checker.sv
// Port-level checks of the oscillator, bound to its top level.
`include "assert_macros.svh"

module cnco_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cnco_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tlast,
    input logic                             m_tuser,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [cnco_pkg::CFG_ADDR_W-1:0]  paddr,
    input logic [cnco_pkg::CFG_DATA_W-1:0]  pwdata,
    input logic [cnco_pkg::CFG_DATA_W-1:0]  prdata
);
    import cnco_pkg::*;

    logic step_wr;

    assign step_wr = psel && penable && pwrite
                  && (paddr[CFG_ADDR_W-1:2] == REG_PHASE_STEP);

    // A stalled sample holds until its transfer.
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser),
                 "stalled sample changed")

    // With the output register empty, the tick side must be open.
    `ASSERT_IMPL(a_ready, aclk, aresetn, !m_tvalid, s_tready,
                 "tick stream blocked with empty output")

    // A flagged step gives zero samples.
    `ASSERT_IMPL(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0,
                 "non-zero sample with step error")

    // A written phase step reads back from the updated register.
    `ASSERT_NEXT(a_readback, aclk, aresetn, step_wr,
                 (paddr[CFG_ADDR_W-1:2] != REG_PHASE_STEP) || (prdata == $past(pwdata)),
                 "phase step read-back mismatch")

endmodule

bind complex_nco_generator cnco_checker u_cnco_checker (.*);
